// File: src/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int VAL_W    = 32;

   typedef enum logic [2:0] {
      OP_APPEND      = 3'd0,
      OP_INSERT      = 3'd1,
      OP_REMOVE_LAST = 3'd2,
      OP_REMOVE_AT   = 3'd3,
      OP_DUMP        = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_COMMIT,
      S_DUMP_RD,
      S_DUMP_LD,
      S_RESP
   } state_type;

endpackage

// File: src/positional_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// ordered list of signed 32-bit values with append, insert, remove and dump
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)              | tuser     | tlast
//  req_    | in        | value[31:0], position[36:32]    | operation | -
//  rsp_    | out       | element[31:0], count[36:32]     | status    | final_res
//
//  append, remove-last and unknown codes: the execute step, then the response
//  insert and remove-at: execute, shift, commit, then the response;
//  moves stream through the one read and one write port of the list memory
//  dump: execute, then read, load and response steps for each entry, plus the wait for each response word
//  reset is synchronous and clears the state, length and pending write; stored values are not cleared
//  a stalled response holds the engine: no new word is taken until it completes
// ----------------------------------------------------------------------------
module positional_list_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[36:32], zero pad
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // element[31:0], count[36:32], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast    // final_res
);
   import ple_pkg::*;

   // list storage
   logic [VAL_W-1:0] mem [CAPACITY];

   // control and datapath registers
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_addr_ff, wr_addr_in;
   logic [VAL_W-1:0] rd_data_ff;
   status_type       stat_ff, stat_in;
   logic [VAL_W-1:0] elem_ff, elem_in;
   logic             last_ff, last_in;

   // memory port controls
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [VAL_W-1:0] mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;

   logic             req_fire;
   logic             rsp_fire;
   logic             is_insert;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign is_insert = (op_ff == OP_INSERT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (pos_ff > len_ff || len_ff >= CNT_W'(CAPACITY)) state_in = S_RESP;
                  else                                               state_in = S_SHIFT;
               end
               OP_REMOVE_AT: begin
                  if (len_ff == '0 || pos_ff >= len_ff) state_in = S_RESP;
                  else                                  state_in = S_SHIFT;
               end
               OP_DUMP: begin
                  if (len_ff == '0) state_in = S_RESP;
                  else              state_in = S_DUMP_RD;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SHIFT: begin
            if (left_ff == '0 && !wr_pend_ff) state_in = S_COMMIT;
         end
         S_COMMIT:  state_in = S_RESP;
         S_DUMP_RD: state_in = S_DUMP_LD;
         S_DUMP_LD: state_in = S_RESP;
         S_RESP: begin
            if (rsp_fire) state_in = last_ff ? S_IDLE : S_DUMP_RD;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in      = op_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      ptr_in     = ptr_ff;
      left_in    = left_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      stat_in    = stat_ff;
      elem_in    = elem_ff;
      last_in    = last_ff;
      mem_we     = 1'b0;
      mem_waddr  = ptr_ff;
      mem_wdata  = val_ff;
      mem_re     = 1'b0;
      mem_raddr  = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in  = op_type'(req_tuser);
               val_in = req_tdata[VAL_W-1:0];
               pos_in = req_tdata[VAL_W+CNT_W-1:VAL_W];
            end
         end
         S_EXEC: begin
            stat_in = STAT_OK;
            elem_in = '0;
            last_in = 1'b1;
            unique case (op_ff)
               OP_APPEND: begin
                  if (len_ff >= CNT_W'(CAPACITY)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = len_ff[IDX_W-1:0];
                     mem_wdata = val_ff;
                     len_in    = len_ff + CNT_W'(1);
                  end
               end
               OP_INSERT: begin
                  // entries from the tail down to position move up one slot
                  if (pos_ff > len_ff)                 stat_in = STAT_BADPOS;
                  else if (len_ff >= CNT_W'(CAPACITY)) stat_in = STAT_FULL;
                  left_in = len_ff - pos_ff;
                  ptr_in  = IDX_W'(len_ff - CNT_W'(1));
               end
               OP_REMOVE_LAST: begin
                  if (len_ff == '0) stat_in = STAT_EMPTY;
                  else              len_in  = len_ff - CNT_W'(1);
               end
               OP_REMOVE_AT: begin
                  // entries above position move down one slot
                  if (len_ff == '0)          stat_in = STAT_EMPTY;
                  else if (pos_ff >= len_ff) stat_in = STAT_BADPOS;
                  left_in = len_ff - pos_ff - CNT_W'(1);
                  ptr_in  = IDX_W'(pos_ff + CNT_W'(1));
               end
               OP_DUMP: begin
                  if (len_ff == '0) stat_in = STAT_EMPTY;
                  ptr_in = '0;
               end
               default: ;
            endcase
         end
         S_SHIFT: begin
            // write of the word read last cycle overlaps the next read
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (left_ff != '0) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff;
               left_in    = left_ff - CNT_W'(1);
               wr_pend_in = 1'b1;
               wr_addr_in = is_insert ? ptr_ff + IDX_W'(1) : ptr_ff - IDX_W'(1);
               ptr_in     = is_insert ? ptr_ff - IDX_W'(1) : ptr_ff + IDX_W'(1);
            end
         end
         S_COMMIT: begin
            if (is_insert) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[IDX_W-1:0];
               mem_wdata = val_ff;
               len_in    = len_ff + CNT_W'(1);
            end else begin
               len_in    = len_ff - CNT_W'(1);
            end
         end
         S_DUMP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff;
         end
         S_DUMP_LD: begin
            elem_in = rd_data_ff;
            last_in = ({1'b0, ptr_ff} + CNT_W'(1)) == len_ff;
         end
         S_RESP: begin
            if (rsp_fire && !last_ff) ptr_in = ptr_ff + IDX_W'(1);
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         len_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      ptr_ff     <= ptr_in;
      left_ff    <= left_in;
      wr_addr_ff <= wr_addr_in;
      stat_ff    <= stat_in;
      elem_ff    <= elem_in;
      last_ff    <= last_in;
   end

   // list memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {3'b000, len_ff, elem_ff};
   assign rsp_tuser  = stat_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   // length never exceeds the storage
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   // one word at a time: input is closed while a response is up
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open while response pending");

   // length only moves in the execute and commit steps
   a_len_stable : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC && state_ff != S_COMMIT) |=> $stable(len_ff))
      else $error("length changed outside update step");

   // a non-final response word is always a dump entry with ok status
   a_dump_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == STAT_OK))
      else $error("non-final word with error status");
`endif

endmodule
